// File: rtl/bounded_set_table_assert.svh
// Assertion macros for the bounded set table.
// All checks are sampled on clk and disabled while rst_n is low.
`ifndef BOUNDED_SET_TABLE_ASSERT_SVH
`define BOUNDED_SET_TABLE_ASSERT_SVH

// Same-cycle implication.
`define BST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bounded_set_table: same-cycle check failed");

// Next-cycle implication.
`define BST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bounded_set_table: next-cycle check failed");

`endif

// File: rtl/bst_pkg.sv
`default_nettype none

package bst_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int REQ_W    = 2;
  localparam int ST_W     = 2;
  localparam int COUNT_W  = 7;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int OUT_TDATA_W = 16;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
  localparam logic [ST_W-1:0] ST_ABSENT = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic append;
    logic shift;
    logic emit;
  } bst_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic match;
    logic shift_done;
    logic is_insert;
    logic is_remove;
  } bst_sts_t;

endpackage

`default_nettype wire

// File: rtl/bst_ctrl.sv
`default_nettype none

module bst_ctrl
  import bst_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  input  wire bst_sts_t sts,
  output bst_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPEND,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd        = '0;
    cmd.load   = (state_r == S_IDLE) && in_tvalid;
    cmd.scan   = (state_r == S_SCAN);
    cmd.append = (state_r == S_APPEND);
    cmd.shift  = (state_r == S_SHIFT);
    cmd.emit   = (state_r == S_DONE) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // a new result replaces the one leaving this edge
      if ((state_r == S_DONE) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sts.scan_done) begin
            if (sts.is_insert) begin
              state_r <= S_APPEND;
            end else if (sts.is_remove && sts.match) begin
              state_r <= S_SHIFT;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_APPEND: begin
          state_r <= S_DONE;
        end
        S_SHIFT: begin
          if (sts.shift_done) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/bst_dp.sv
`default_nettype none

`include "bounded_set_table_assert.svh"

module bst_dp
  import bst_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bst_cmd_t          cmd,
  output bst_sts_t               sts,
  input  wire logic [REQ_W-1:0]  in_req_type,
  input  wire logic [DATA_W-1:0] in_value,
  output logic                   out_found,
  output logic [ST_W-1:0]        out_status,
  output logic [COUNT_W-1:0]     out_count
);

  logic [DATA_W-1:0] mem [CAPACITY];

  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] rdata_r;
  logic [REQ_W-1:0]  kind_r;
  logic [CNT_W-1:0]  fill_r;
  logic [CNT_W-1:0]  idx_r;
  logic [ADDR_W-1:0] wptr_r;
  logic              pend_r;
  logic              hit_r;
  logic [ST_W-1:0]   stat_r;

  logic              match;
  logic              more;
  logic              room;
  logic              rd_en;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;

  // pend_r marks that rdata_r holds the entry just below idx_r
  assign match = pend_r && (rdata_r == val_r);
  assign more  = idx_r < fill_r;
  assign room  = fill_r < CNT_W'(CAPACITY);

  assign rd_en   = (cmd.scan && !match && more) || (cmd.shift && more);
  assign wr_en   = (cmd.append && room) || (cmd.shift && pend_r);
  assign wr_addr = cmd.append ? fill_r[ADDR_W-1:0] : wptr_r;
  assign wr_data = cmd.append ? val_r : rdata_r;

  always_comb begin
    sts            = '0;
    sts.scan_done  = match || !more;
    sts.match      = match;
    sts.shift_done = !more && !pend_r;
    sts.is_insert  = (kind_r == REQ_INSERT);
    sts.is_remove  = (kind_r == REQ_REMOVE);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[idx_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      pend_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        val_r  <= in_value;
        kind_r <= in_req_type;
        idx_r  <= '0;
        pend_r <= 1'b0;
        hit_r  <= 1'b0;
        stat_r <= ST_OK;
      end
      if (cmd.scan) begin
        if (match) begin
          // idx_r already points one past the hit: shift starts from there
          hit_r  <= 1'b1;
          wptr_r <= ADDR_W'(idx_r - CNT_W'(1));
          pend_r <= 1'b0;
        end else if (more) begin
          idx_r  <= idx_r + CNT_W'(1);
          pend_r <= 1'b1;
        end else begin
          pend_r <= 1'b0;
          if (kind_r == REQ_REMOVE) begin
            stat_r <= ST_ABSENT;
          end
        end
      end
      if (cmd.append) begin
        if (room) begin
          fill_r <= fill_r + CNT_W'(1);
        end else begin
          stat_r <= ST_FULL;
        end
      end
      if (cmd.shift) begin
        if (pend_r) begin
          wptr_r <= wptr_r + ADDR_W'(1);
        end
        if (more) begin
          idx_r  <= idx_r + CNT_W'(1);
          pend_r <= 1'b1;
        end else begin
          pend_r <= 1'b0;
          if (!pend_r) begin
            fill_r <= fill_r - CNT_W'(1);
          end
        end
      end
      if (cmd.emit) begin
        out_found  <= hit_r;
        out_status <= stat_r;
        out_count  <= COUNT_W'(fill_r);
      end
    end
  end

  `BST_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= CNT_W'(CAPACITY))
  `BST_ASSERT_NOW(a_idx_bound, cmd.scan || cmd.shift, idx_r <= fill_r)
  `BST_ASSERT_NEXT(a_append_grows, cmd.append && room, fill_r == $past(fill_r) + CNT_W'(1))
  `BST_ASSERT_NEXT(a_remove_shrinks, cmd.shift && !more && !pend_r,
                   fill_r == $past(fill_r) - CNT_W'(1))

endmodule

`default_nettype wire

// File: rtl/bounded_set_table.sv
// Bounded set table: up to CAPACITY (64) signed 32-bit values kept compact
// in insertion order, with a fill count.
// Input channel (in_*): in_tuser carries the request kind (insert, remove,
//   lookup; code three acts as lookup), in_tdata the 32-bit value.
// Result channel (out_*): one item per request with found (value present
//   before the request), status (ok / full on insert / absent on remove)
//   and the count after the request.
// Timing: a request is taken only while the table is idle. The scan reads
//   one stored entry per cycle from a memory with a registered read port and
//   stops at the first hit. A lookup only scans; an insert scans, then appends;
//   a remove that hits scans to the hit, then moves each later entry down one
//   per cycle.
// The result sits in an output register, so the next request is taken while
//   the previous result still waits; if the receiver stalls, the finished
//   request waits in its last step until the register frees up.
// Reset (rst_n low, synchronous) empties the table and drops any pending
//   result; the entry memory is not cleared, only positions below the count
//   are ever read.
`default_nettype none

module bounded_set_table
  import bst_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [DATA_W-1:0]      in_tdata,   // [31:0] value
  input  wire logic [REQ_W-1:0]       in_tuser,   // [1:0] req_type
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata   // [0] found, [2:1] status,
                                                  // [9:3] count, rest zero
);

  bst_cmd_t           cmd;
  bst_sts_t           sts;
  logic               found;
  logic [ST_W-1:0]    status;
  logic [COUNT_W-1:0] count;

  bst_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  bst_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_req_type (in_tuser),
    .in_value    (in_tdata),
    .out_found   (found),
    .out_status  (status),
    .out_count   (count)
  );

  assign out_tdata = {{(OUT_TDATA_W - COUNT_W - ST_W - 1){1'b0}}, count, status, found};

endmodule

`default_nettype wire

// File: tb/sv/bounded_set_table_checker.sv
`timescale 1ns / 1ps

module bounded_set_table_checker
  import bst_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  input  wire logic                   in_tready,
  input  wire logic [DATA_W-1:0]      in_tdata,   // [31:0] value
  input  wire logic [REQ_W-1:0]       in_tuser,   // [1:0] req_type
  input  wire logic                   out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic [OUT_TDATA_W-1:0] out_tdata,  // [0] found, [2:1] status, [9:3] count
  output int                          errs,
  output int                          waiting,
  output int                          answered,
  output int                          full_refusals,
  output int                          remove_misses,
  output int                          hits,
  output int                          peak_fill
);

  typedef struct packed {
    logic               found;
    logic [ST_W-1:0]    status;
    logic [COUNT_W-1:0] count;
  } reply_t;

  // shadow copy of the table
  logic [DATA_W-1:0] shadow_vals [CAPACITY];
  int                shadow_fill = 0;
  reply_t            replies_due [$];

  initial begin
    errs = 0;
    waiting = 0;
    answered = 0;
    full_refusals = 0;
    remove_misses = 0;
    hits = 0;
    peak_fill = 0;
  end

  // applies one request to the shadow table and returns the reply it earns
  function automatic reply_t apply_request(input logic [REQ_W-1:0] kind,
                                           input logic [DATA_W-1:0] v);
    int     pos;
    int     j;
    reply_t r;
    pos = shadow_fill;
    for (j = shadow_fill - 1; j >= 0; j--) begin
      if (shadow_vals[j] == v) pos = j;   // lowest position wins
    end
    r.found  = (pos < shadow_fill);
    r.status = ST_OK;
    case (kind)
      REQ_INSERT: begin
        if (shadow_fill < CAPACITY) begin
          shadow_vals[shadow_fill] = v;
          shadow_fill++;
        end else begin
          r.status = ST_FULL;
        end
      end
      REQ_REMOVE: begin
        if (r.found) begin
          for (j = pos; j < shadow_fill - 1; j++) shadow_vals[j] = shadow_vals[j + 1];
          shadow_fill--;
        end else begin
          r.status = ST_ABSENT;
        end
      end
      default: ;  // lookup and the spare code leave the table alone
    endcase
    r.count = shadow_fill[COUNT_W-1:0];
    return r;
  endfunction

  task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
    errs++;
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin : watch
    reply_t                 want;
    logic [OUT_TDATA_W-1:0] got;
    if (!rst_n) begin
      shadow_fill = 0;
      replies_due.delete();
    end else begin
      // a result leaving this edge belongs to an earlier request, so pop first
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (replies_due.size() == 0) begin
          errs++;
          $display("%0t ns: result with nothing pending, expected none, got 0x%h",
                   $time, got);
        end else begin
          want = replies_due.pop_front();
          if (got[0] !== want.found) flag("found", want.found, got[0]);
          if (got[2:1] !== want.status) flag("status", want.status, got[2:1]);
          if (got[9:3] !== want.count) flag("count", want.count, got[9:3]);
          if (got[OUT_TDATA_W-1:10] !== '0) flag("padding", 0, got[OUT_TDATA_W-1:10]);
          answered++;
          if (want.status == ST_FULL) full_refusals++;
          if (want.status == ST_ABSENT) remove_misses++;
          if (want.found) hits++;
        end
      end
      if (in_tvalid && in_tready) begin
        replies_due.push_back(apply_request(in_tuser, in_tdata));
        if (shadow_fill > peak_fill) peak_fill = shadow_fill;
      end
    end
    waiting <= replies_due.size();
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bst_pkg::*;

  // request code three has no name in the package; the block treats it as a lookup
  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

  localparam int POOL_N      = 12;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 200;
  // longest request (scan to the hit, then compaction of the rest) plus the
  // longest receiver stall, with margin
  localparam int SETTLE      = 2 * CAPACITY + 16;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [DATA_W-1:0]      in_tdata   = '0;
  logic [REQ_W-1:0]       in_tuser   = REQ_LOOKUP;
  logic                   out_tready = 1'b0;
  logic                   in_tready;
  logic                   out_tvalid;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // quiet: no gaps and no stalls on either side for the current phase
  bit                quiet = 1'b0;
  int                hold_left = 0;
  logic [DATA_W-1:0] pool [POOL_N];

  int errs, waiting, answered, full_refusals, remove_misses, hits, peak_fill;

  bounded_set_table u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  bounded_set_table_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .errs          (errs),
    .waiting       (waiting),
    .answered      (answered),
    .full_refusals (full_refusals),
    .remove_misses (remove_misses),
    .hits          (hits),
    .peak_fill     (peak_fill)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop; a clean run needs well under a tenth of this
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // receiver: mostly ready, short stalls, now and then a long one
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (quiet) begin
      hold_left = 0;
      out_tready <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < 65) begin
      out_tready <= 1'b1;
    end else begin
      hold_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 40);
      out_tready <= 1'b0;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mostly values from a small pool so hits, duplicates and removes happen;
  // the rest fully random so every value bit moves
  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 75) return pool[$urandom_range(0, POOL_N - 1)];
    return $urandom();
  endfunction

  function automatic logic [REQ_W-1:0] pick_kind(input int ins_w, input int rem_w);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return REQ_SPARE;
    if (r < 4 + ins_w) return REQ_INSERT;
    if (r < 4 + ins_w + rem_w) return REQ_REMOVE;
    return REQ_LOOKUP;
  endfunction

  // presents one item and returns at the edge that takes it; valid stays
  // high into the next item when no gap is drawn
  task automatic send(input logic [REQ_W-1:0] kind, input logic [DATA_W-1:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= val;
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin : stimulus
    int ph;
    int ins_w;
    int rem_w;
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7fff_ffff;
    pool[2] = 32'h0000_0000;
    pool[3] = 32'hffff_ffff;
    pool[4] = 32'h0000_0001;
    for (int i = 5; i < POOL_N; i++) pool[i] = $urandom();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, extremes, duplicates, shifts, spare code
    send(REQ_LOOKUP, 32'd5);             // lookup on empty table
    send(REQ_REMOVE, 32'd5);             // remove on empty table: absent
    send(REQ_INSERT, 32'h8000_0000);
    send(REQ_INSERT, 32'h7fff_ffff);
    send(REQ_INSERT, 32'h0000_0000);
    send(REQ_INSERT, 32'hffff_ffff);
    send(REQ_INSERT, 32'h7fff_ffff);     // duplicate goes in again, found set
    send(REQ_LOOKUP, 32'h8000_0000);
    send(REQ_LOOKUP, 32'h7fff_fffe);     // near miss, one bit off
    send(REQ_REMOVE, 32'h7fff_ffff);     // first copy, middle: later entries move down
    send(REQ_LOOKUP, 32'h7fff_ffff);     // second copy still there
    send(REQ_SPARE,  32'h0000_0000);     // spare code acts as a lookup
    send(REQ_SPARE,  32'h1234_5678);
    send(REQ_REMOVE, 32'h8000_0000);     // head entry
    send(REQ_REMOVE, 32'h7fff_ffff);     // tail entry
    send(REQ_REMOVE, 32'h1234_5678);     // absent
    send(REQ_INSERT, 32'h5555_5555);
    send(REQ_INSERT, 32'haaaa_aaaa);
    send(REQ_LOOKUP, 32'haaaa_aaaa);

    // random: phases that fill the table past full, drain it, and churn it
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph % 3)
        0: begin
          ins_w = 70;
          rem_w = 16;
        end
        1: begin
          ins_w = 15;
          rem_w = 65;
        end
        default: begin
          ins_w = 40;
          rem_w = 35;
        end
      endcase
      quiet = (ph % 4 == 3);
      repeat (PHASE_ITEMS) send(pick_kind(ins_w, rem_w), pick_value());
    end
    quiet = 1'b0;
    in_tvalid <= 1'b0;

    while (waiting != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("%0d requests answered, table peaked at %0d of %0d entries;",
             answered, peak_fill, CAPACITY);
    $display("%0d inserts refused as full, %0d removes missed, %0d hits.",
             full_refusals, remove_misses, hits);
    if (errs == 0 && waiting == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
